>>> design/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the clipped 3x3 box blur
// Sizes, the command record passed from the front to the back end, and the
// reciprocal table used for the divide by the window pixel count.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 1024;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);

  // One column of up to three pixels, and the full window of up to nine.
  localparam int CSUM_W    = PIX_W + 2;
  localparam int SUM_W     = PIX_W + 4;
  localparam int CNT_W     = 4;
  localparam int FRAC_W    = 16;
  localparam int RECIP_W   = FRAC_W + 1;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Work for the back end, fully classified by the front end.
  typedef struct packed {
    op_t              kind;
    logic [ROW_W-1:0] row;       // row of the results
    logic [COL_W-1:0] col;       // input column, or drain column
    logic [PIX_W-1:0] pixel;
    logic             emit_a;    // result one column back
    logic             emit_b;    // extra result at the last column
    logic             top_ok;    // upper window row exists
    logic             right_ok;  // right window column exists (drain)
    logic             prime;     // first drain: load two columns
    logic             done;      // final result of the frame
  } cmd_t;

  // ceil(2^FRAC_W / count); exact floor for every window sum.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/bb3_in_if.sv
// ----------------------------------------------------------------------------
// bb3_in_if: input pixel channel
// Valid/ready channel carrying one pixel or one drain tick per transaction.
// ----------------------------------------------------------------------------
interface bb3_in_if import bb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output op, output pixel_value, input ready);
  modport sink (input valid, input op, input pixel_value, output ready);
endinterface

>>> design/bb3_out_if.sv
// ----------------------------------------------------------------------------
// bb3_out_if: output result channel
// Valid/ready channel carrying one blurred pixel per transaction.
// ----------------------------------------------------------------------------
interface bb3_out_if import bb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blurred_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             frame_done;
  logic             last;

  modport source (output valid, output blurred_value, output out_row, output out_col,
                  output frame_done, output last, input ready);
  modport sink (input valid, input blurred_value, input out_row, input out_col,
                input frame_done, input last, output ready);
endinterface

>>> design/bb3_front.sv
// ----------------------------------------------------------------------------
// bb3_front: input classifier
// Tracks the frame position, holds the configuration and turns each accepted
// transaction into a back-end command, or drops it.
// ----------------------------------------------------------------------------
module bb3_front import bb3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bb3_in_if.sink               pixels,
  input  logic                 queue_full,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic [CFG_W-1:0] rows_cfg;
  logic [CFG_W-1:0] cols_cfg;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [CFG_W-1:0] drain_col;
  logic             frame_complete;

  logic [CFG_W-1:0] nr_eff;
  logic [CFG_W-1:0] nc_eff;
  logic [CFG_W-1:0] nr_m1;
  logic [CFG_W-1:0] nc_m1;
  logic [CFG_W-1:0] drain_next;
  logic             last_col;
  logic             last_row;
  logic             accept;
  logic             is_drain;

  always_comb begin
    if (rows_cfg == '0) begin
      nr_eff = CFG_W'(1);
    end else if (rows_cfg > CFG_W'(MAX_ROWS)) begin
      nr_eff = CFG_W'(MAX_ROWS);
    end else begin
      nr_eff = rows_cfg;
    end
    if (cols_cfg == '0) begin
      nc_eff = CFG_W'(1);
    end else if (cols_cfg > CFG_W'(MAX_COLS)) begin
      nc_eff = CFG_W'(MAX_COLS);
    end else begin
      nc_eff = cols_cfg;
    end
  end

  assign nr_m1      = nr_eff - CFG_W'(1);
  assign nc_m1      = nc_eff - CFG_W'(1);
  assign drain_next = drain_col + CFG_W'(1);
  assign last_col   = (CFG_W'(in_col) == nc_m1);
  assign last_row   = (CFG_W'(in_row) == nr_m1);

  assign pixels.ready = !queue_full;
  assign accept       = pixels.valid && pixels.ready;
  assign is_drain     = (pixels.op == OP_DRAIN);

  // Drain ticks count only after the frame; pixels only before its end.
  assign push = accept && (is_drain ? frame_complete : !frame_complete);

  always_comb begin
    push_cmd = '0;
    if (is_drain) begin
      push_cmd.kind     = OP_DRAIN;
      push_cmd.row      = nr_m1[ROW_W-1:0];
      push_cmd.col      = drain_col[COL_W-1:0];
      push_cmd.top_ok   = (nr_eff >= CFG_W'(2));
      push_cmd.right_ok = (drain_next < nc_eff);
      push_cmd.prime    = (drain_col == '0);
      push_cmd.done     = (drain_col == nc_m1);
    end else begin
      push_cmd.kind   = OP_PIXEL;
      push_cmd.row    = in_row - ROW_W'(1);
      push_cmd.col    = in_col;
      push_cmd.pixel  = pixels.pixel_value;
      push_cmd.emit_a = (in_row != '0) && (in_col != '0);
      push_cmd.emit_b = (in_row != '0) && last_col;
      push_cmd.top_ok = (in_row >= ROW_W'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg       <= CFG_W'(MAX_ROWS);
      cols_cfg       <= CFG_W'(MAX_COLS);
      in_row         <= '0;
      in_col         <= '0;
      drain_col      <= '0;
      frame_complete <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROWS: rows_cfg <= cfg_data;
        CFG_COLS: cols_cfg <= cfg_data;
      endcase
      in_row         <= '0;
      in_col         <= '0;
      drain_col      <= '0;
      frame_complete <= 1'b0;
    end else if (push) begin
      if (is_drain) begin
        if (drain_next >= nc_eff) begin
          in_row         <= '0;
          in_col         <= '0;
          drain_col      <= '0;
          frame_complete <= 1'b0;
        end else begin
          drain_col <= drain_next;
        end
      end else if (last_col) begin
        in_col <= '0;
        if (last_row) begin
          frame_complete <= 1'b1;
        end else begin
          in_row <= in_row + ROW_W'(1);
        end
      end else begin
        in_col <= in_col + COL_W'(1);
      end
    end
  end

  a_complete_at_row_start: assert property (@(posedge clk) disable iff (rst)
    frame_complete |-> (in_col == '0))
    else $error("frame complete away from column zero");

  a_drain_only_after_frame: assert property (@(posedge clk) disable iff (rst)
    (drain_col != '0) |-> frame_complete)
    else $error("drain in progress before frame complete");

endmodule

>>> design/bb3_cmd_queue.sv
// ----------------------------------------------------------------------------
// bb3_cmd_queue: command queue
// Short FIFO of classified commands between the front and back end.
// ----------------------------------------------------------------------------
module bb3_cmd_queue import bb3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("command queue underflow");

endmodule

>>> design/bb3_back.sv
// ----------------------------------------------------------------------------
// bb3_back: window engine
// Keeps two past rows per column in a line memory, slides a window of column
// sums, and forms each clipped mean by a reciprocal multiply.
// ----------------------------------------------------------------------------
module bb3_back import bb3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic pop,
  bb3_out_if.source results
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SUM,
    S_DIV
  } state_t;

  state_t state;
  cmd_t   cur;
  logic   phase_b;
  logic   primed;

  // Line memory: per column, {row two back, row one back}.
  logic [2*PIX_W-1:0] line_mem [MAX_COLS];
  logic [2*PIX_W-1:0] rd_data;
  logic               rd_en;
  logic [COL_W-1:0]   rd_addr;
  logic               wr_en;
  logic [PIX_W-1:0]   rd_older;
  logic [PIX_W-1:0]   rd_newer;

  logic [CSUM_W-1:0]  w0;
  logic [CSUM_W-1:0]  w1;
  logic [CSUM_W-1:0]  w2;
  logic [CSUM_W-1:0]  col_sum;
  logic               second_read;

  logic [CSUM_W-1:0]  win_l;
  logic [CSUM_W-1:0]  win_c;
  logic [CSUM_W-1:0]  win_r;
  logic               left_ok;
  logic               right_ok;
  logic [1:0]         rows_n;
  logic [1:0]         cols_n;
  logic [SUM_W-1:0]   sum_next;

  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [ROW_W-1:0]   res_row;
  logic [COL_W-1:0]   res_col;
  logic               res_done;
  logic               res_last;
  logic [SUM_W+RECIP_W-1:0] product;
  logic               out_free;

  assign pop         = (state == S_IDLE) && cmd_valid;
  assign second_read = (state == S_SHIFT) && (cur.kind == OP_DRAIN) && cur.prime && !primed;
  assign rd_en       = pop || second_read;
  assign wr_en       = (state == S_SHIFT) && (cur.kind == OP_PIXEL);
  assign rd_older    = rd_data[2*PIX_W-1:PIX_W];
  assign rd_newer    = rd_data[PIX_W-1:0];

  always_comb begin
    if (second_read) begin
      rd_addr = COL_W'(1);
    end else if (cmd.kind == OP_PIXEL) begin
      rd_addr = cmd.col;
    end else if (cmd.prime) begin
      rd_addr = '0;
    end else begin
      rd_addr = cmd.col + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= line_mem[rd_addr];
    end
    if (wr_en) begin
      line_mem[cur.col] <= {rd_newer, cur.pixel};
    end
  end

  // Column sum of the rows that exist for this item.
  always_comb begin
    col_sum = CSUM_W'(rd_newer);
    if (cur.top_ok) begin
      col_sum = col_sum + CSUM_W'(rd_older);
    end
    if (cur.kind == OP_PIXEL) begin
      col_sum = col_sum + CSUM_W'(cur.pixel);
    end
  end

  // Window selection for the result being formed.
  always_comb begin
    win_l    = w0;
    win_c    = w1;
    win_r    = w2;
    left_ok  = 1'b0;
    right_ok = 1'b0;
    if (cur.kind == OP_DRAIN) begin
      left_ok  = (cur.col != '0);
      right_ok = cur.right_ok;
    end else if (!phase_b) begin
      left_ok  = (cur.col >= COL_W'(2));
      right_ok = 1'b1;
    end else begin
      win_l    = w1;
      win_c    = w2;
      win_r    = '0;
      left_ok  = (cur.col != '0);
    end
    rows_n   = (cur.kind == OP_DRAIN) ? 2'd1 : 2'd2;
    rows_n   = rows_n + {1'b0, cur.top_ok};
    cols_n   = 2'd1 + {1'b0, left_ok} + {1'b0, right_ok};
    sum_next = SUM_W'(win_c);
    if (left_ok) begin
      sum_next = sum_next + SUM_W'(win_l);
    end
    if (right_ok) begin
      sum_next = sum_next + SUM_W'(win_r);
    end
  end

  assign product  = sum_q * recip(cnt_q);
  assign out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase_b       <= 1'b0;
      primed        <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (state == S_DIV && out_free) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur     <= cmd;
            phase_b <= 1'b0;
            primed  <= 1'b0;
            state   <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          w0 <= w1;
          w1 <= w2;
          w2 <= col_sum;
          if (second_read) begin
            primed <= 1'b1;
          end else if (cur.kind == OP_DRAIN || cur.emit_a) begin
            state <= S_SUM;
          end else if (cur.emit_b) begin
            phase_b <= 1'b1;
            state   <= S_SUM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          sum_q    <= sum_next;
          cnt_q    <= CNT_W'(rows_n) * CNT_W'(cols_n);
          res_row  <= cur.row;
          res_col  <= (cur.kind == OP_PIXEL && !phase_b) ? cur.col - COL_W'(1) : cur.col;
          res_done <= (cur.kind == OP_DRAIN) && cur.done;
          res_last <= (cur.kind == OP_DRAIN) || phase_b || !cur.emit_b;
          state    <= S_DIV;
        end
        S_DIV: begin
          if (out_free) begin
            results.blurred_value <= product[FRAC_W +: PIX_W];
            results.out_row       <= res_row;
            results.out_col       <= res_col;
            results.frame_done    <= res_done;
            results.last          <= res_last;
            if (cur.kind == OP_PIXEL && !phase_b && cur.emit_b) begin
              phase_b <= 1'b1;
              state   <= S_SUM;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt_q == 4'd1 || cnt_q == 4'd2 || cnt_q == 4'd3 ||
                          cnt_q == 4'd4 || cnt_q == 4'd6 || cnt_q == 4'd9))
    else $error("window pixel count out of range");

  a_second_result_only_at_row_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && phase_b) |-> (cur.kind == OP_PIXEL && cur.emit_b))
    else $error("row end result without row end");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("line memory read and write in one cycle");

endmodule

>>> design/box_blur_3x3_clipped.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_clipped: streaming 3x3 mean filter with clipped borders
// Top level: input classifier, command queue and window engine.
// ----------------------------------------------------------------------------
// Path: a result passes from the accepted pixel or drain tick through the
//   command queue, then the engine's shift, sum and divide states, into the
//   output register; a second result at a row end repeats sum and divide.
// Engine: it takes a new command only from idle; a pixel without result
//   returns to idle after the shift, a result adds sum and divide, and the
//   first drain tick shifts twice; the single line memory port sets that.
// Reset: control state clears and both size registers go to 1024; the line
//   memory is left as it is and is only used where written in this frame.
// ----------------------------------------------------------------------------
module box_blur_3x3_clipped import bb3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bb3_in_if.sink               pixels,
  bb3_out_if.source            results
);

  // Front end to queue.
  logic push;
  cmd_t push_cmd;
  logic queue_full;

  // Queue to back end.
  logic pop;
  logic head_valid;
  cmd_t head;

  // Classify each transaction: a pixel of the frame, a drain tick, or
  // something to drop. The front end keeps the frame position, so it can run
  // ahead of the window engine by as many commands as the queue holds.
  bb3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixels     (pixels),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Hold classified commands while the window engine works on one item.
  bb3_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Read the two stored rows at the column, update the line memory, slide
  // the column-sum window, then add the clipped window and divide by the
  // pixel count. The output register frees the engine from the consumer
  // for one result.
  bb3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head),
    .pop       (pop),
    .results   (results)
  );

endmodule

>>> test/blur_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur_monitor: result prediction and comparison for the clipped 3x3 blur
// Follows register writes and accepted input transactions, keeps its own line
// store and frame position, and checks every accepted result against the
// oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module blur_monitor import bb3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bb3_in_if                    pixels,
  bb3_out_if                   results,
  output int                   mismatches,
  output int                   backlog
);

  localparam int REPORT_CAP = 200;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
    logic             last;
  } blur_pix_t;

  logic [PIX_W-1:0] lines [3*MAX_COLS];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  logic [ROW_W-1:0] next_row;
  logic [COL_W-1:0] next_col;
  logic [CFG_W-1:0] drain_pos;
  logic             frame_full;
  blur_pix_t        pending_blurs [$];

  function automatic int fit_size(logic [CFG_W-1:0] raw, int top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return int'(raw);
  endfunction

  function automatic void rewind_frame();
    next_row   = '0;
    next_col   = '0;
    drain_pos  = '0;
    frame_full = 1'b0;
  endfunction

  // Floor mean of the window around (r,c), clipped to the frame.
  function automatic blur_pix_t blur_at(int r, int c, int nr, int nc, logic done);
    int r0, r1, c0, c1, sum, cnt, i, j;
    blur_pix_t p;
    r0  = (r > 0) ? r - 1 : 0;
    r1  = (r + 1 < nr) ? r + 1 : nr - 1;
    c0  = (c > 0) ? c - 1 : 0;
    c1  = (c + 1 < nc) ? c + 1 : nc - 1;
    sum = 0;
    cnt = 0;
    for (i = r0; i <= r1; i++) begin
      for (j = c0; j <= c1; j++) begin
        sum += int'(lines[(i % 3) * MAX_COLS + j]);
        cnt++;
      end
    end
    p.value = PIX_W'(sum / cnt);
    p.row   = ROW_W'(r);
    p.col   = COL_W'(c);
    p.done  = done;
    p.last  = 1'b0;
    return p;
  endfunction

  function automatic void predict_blur(op_t op, logic [PIX_W-1:0] px);
    int nr, nc, r, c, n, k;
    blur_pix_t made [2];
    nr = fit_size(rows_reg, MAX_ROWS);
    nc = fit_size(cols_reg, MAX_COLS);
    n  = 0;
    if (op == OP_DRAIN) begin
      // Drain ticks only count once the whole frame is in.
      if (frame_full) begin
        if (drain_pos >= nc) begin
          rewind_frame();
        end else begin
          c = int'(drain_pos);
          made[0] = blur_at(nr - 1, c, nr, nc, c == nc - 1);
          made[0].last = 1'b1;
          pending_blurs.push_back(made[0]);
          drain_pos = drain_pos + 1'b1;
          if (drain_pos >= nc) rewind_frame();
        end
      end
    end else if (!frame_full) begin
      if (next_row >= nr || next_col >= nc) rewind_frame();
      r = int'(next_row);
      c = int'(next_col);
      lines[(r % 3) * MAX_COLS + c] = px;
      if (r >= 1 && c >= 1) begin
        made[n] = blur_at(r - 1, c - 1, nr, nc, 1'b0);
        n++;
      end
      if (r >= 1 && c == nc - 1) begin
        made[n] = blur_at(r - 1, nc - 1, nr, nc, 1'b0);
        n++;
      end
      if (n > 0) made[n-1].last = 1'b1;
      for (k = 0; k < n; k++) pending_blurs.push_back(made[k]);
      if (c == nc - 1) begin
        next_col = '0;
        if (r == nr - 1) frame_full = 1'b1;
        else next_row = next_row + 1'b1;
      end else begin
        next_col = next_col + 1'b1;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  function automatic void match_result();
    blur_pix_t want;
    if (pending_blurs.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("unexpected result: row %0d col %0d value %0d",
               results.out_row, results.out_col, results.blurred_value);
    end else begin
      want = pending_blurs.pop_front();
      check_field("blurred_value", 32'(want.value), 32'(results.blurred_value));
      check_field("out_row", 32'(want.row), 32'(results.out_row));
      check_field("out_col", 32'(want.col), 32'(results.out_col));
      check_field("frame_done", 32'(want.done), 32'(results.frame_done));
      check_field("last", 32'(want.last), 32'(results.last));
    end
  endfunction

  always @(posedge clk) begin : watch
    int k;
    if (rst) begin
      for (k = 0; k < 3 * MAX_COLS; k++) lines[k] = '0;
      rows_reg = CFG_W'(MAX_ROWS);
      cols_reg = CFG_W'(MAX_COLS);
      rewind_frame();
      pending_blurs.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_ROWS) rows_reg = cfg_data;
        else if (cfg_index == CFG_COLS) cols_reg = cfg_data;
        rewind_frame();
      end
      if (pixels.valid && pixels.ready) predict_blur(op_t'(pixels.op), pixels.pixel_value);
      if (results.valid && results.ready) match_result();
    end
    backlog = pending_blurs.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the clipped 3x3 box blur
// Drives frames of pixels and drain ticks with random gaps on both channels,
// changes the frame size between phases, and reports the verdict from the
// monitor's comparison of every result.
// ----------------------------------------------------------------------------
module tb;
  import bb3_pkg::*;

  localparam int ITEM_TARGET   = 1650;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Longer than a full queue of two-result items takes to retire.
  localparam int SETTLE_CYCLES = 30;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   backlog;
  int                   cycles = 0;

  // Frame size as written, and as the block sees it after clamping.
  logic [CFG_W-1:0]     rows_raw;
  logic [CFG_W-1:0]     cols_raw;
  int                   rows_now;
  int                   cols_now;
  // Transactions that advance a frame; ignored and dropped ones do not count.
  int                   frame_items;
  bit                   tx_steady = 1'b0;
  bit                   rx_steady = 1'b0;

  bb3_in_if  pixels_if ();
  bb3_out_if results_if ();

  box_blur_3x3_clipped dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels_if),
    .results   (results_if)
  );

  blur_monitor monitor (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixels     (pixels_if),
    .results    (results_if),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int fit_size(logic [CFG_W-1:0] raw, int top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return int'(raw);
  endfunction

  // Mostly tiny sizes, sometimes medium, rarely larger.
  function automatic logic [CFG_W-1:0] draw_size(int tiny, int mid, int wide);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: return CFG_W'($urandom_range(1, tiny));
      7, 8:                return CFG_W'($urandom_range(tiny + 1, mid));
      default:             return CFG_W'($urandom_range(mid + 1, wide));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one transaction; called and returning at a falling edge. Valid stays
  // high on return so that a back-to-back item needs only one update.
  task automatic push_item(input op_t op, input logic [PIX_W-1:0] px);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      pixels_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixels_if.valid       <= 1'b1;
    pixels_if.op          <= op;
    pixels_if.pixel_value <= px;
    @(posedge clk);
    while (!pixels_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the input idle until every predicted result is back and the block
  // has had time to retire any item that produces nothing.
  task automatic settle();
    pixels_if.valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_ROWS) rows_raw = val;
    else cols_raw = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Any write restarts the frame, so a phase always begins on a clean frame.
  task automatic reconfigure(input bit set_rows, input bit set_cols,
                             input logic [CFG_W-1:0] nrows, input logic [CFG_W-1:0] ncols);
    settle();
    if (set_rows) write_reg(CFG_ROWS, nrows);
    if (set_cols) write_reg(CFG_COLS, ncols);
    rows_now = fit_size(rows_raw, MAX_ROWS);
    cols_now = fit_size(cols_raw, MAX_COLS);
  endtask

  // One frame: all pixels in raster order, then one drain tick per column.
  // Sprinkle early drain ticks among the pixels and stray pixels among the
  // drain ticks. A non-negative cut stops the frame after that many steps.
  task automatic run_frame(input int cut);
    int total, npix, k;
    npix      = rows_now * cols_now;
    total     = npix + cols_now;
    tx_steady = ($urandom_range(0, 3) == 0);
    for (k = 0; k < total; k++) begin
      if (cut >= 0 && k == cut) break;
      if (k < npix) begin
        if ($urandom_range(0, 15) == 0) push_item(OP_DRAIN, draw_pixel());
        push_item(OP_PIXEL, draw_pixel());
      end else begin
        if ($urandom_range(0, 15) == 0) push_item(OP_PIXEL, draw_pixel());
        push_item(OP_DRAIN, draw_pixel());
      end
      frame_items++;
    end
  endtask

  // Result side: draw a stall before each result, with steady stretches.
  initial begin : result_sink
    int gap;
    results_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 47) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      results_if.ready <= 1'b1;
      @(posedge clk);
      while (!results_if.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [PIX_W-1:0] checker_board [9] = '{8'd255, 8'd0, 8'd255,
                                            8'd0, 8'd255, 8'd0,
                                            8'd255, 8'd0, 8'd255};
    int i, pick, nframes, f, total, cut;

    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_index             = CFG_ROWS;
    cfg_data              = '0;
    pixels_if.valid       = 1'b0;
    pixels_if.op          = OP_PIXEL;
    pixels_if.pixel_value = '0;
    rows_raw              = CFG_W'(MAX_ROWS);
    cols_raw              = CFG_W'(MAX_COLS);
    frame_items           = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 3x3 frame: corners, edges and center each see a different window size
    // (4, 6 and 9 pixels). Add a drain tick before the frame is complete,
    // which must be ignored, and a pixel during the drain, which must be
    // dropped.
    reconfigure(1'b1, 1'b1, 11'd3, 11'd3);
    push_item(OP_DRAIN, 8'd0);
    for (i = 0; i < 9; i++) push_item(OP_PIXEL, checker_board[i]);
    push_item(OP_DRAIN, 8'd0);
    push_item(OP_PIXEL, 8'd255);
    push_item(OP_DRAIN, 8'd255);
    push_item(OP_DRAIN, 8'd0);

    // Single pixel frame: the window is the pixel itself.
    reconfigure(1'b1, 1'b1, 11'd1, 11'd1);
    push_item(OP_PIXEL, 8'd255);
    push_item(OP_DRAIN, 8'd0);

    // One-row frame: every result comes from a drain tick, windows of 2 and 3.
    reconfigure(1'b0, 1'b1, 11'd0, 11'd3);
    push_item(OP_PIXEL, 8'd200);
    push_item(OP_PIXEL, 8'd100);
    push_item(OP_PIXEL, 8'd7);
    repeat (3) push_item(OP_DRAIN, 8'd0);

    // Out-of-range sizes clamp to 1 and 1024; run these in part only. The
    // tall single-column frame walks the row counter well past the others.
    reconfigure(1'b1, 1'b1, 11'd2047, 11'd0);
    run_frame(40);
    reconfigure(1'b1, 1'b1, 11'd1024, 11'd1024);
    run_frame(25);
    reconfigure(1'b1, 1'b1, 11'd0, 11'd2047);
    run_frame(25);
    reconfigure(1'b1, 1'b1, 11'd1, 11'd1);
    run_frame(-1);
    run_frame(-1);

    // Random phases: new size on one or both registers, a few whole frames,
    // now and then one cut short. Large frames are always cut.
    while (frame_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 2);
      reconfigure(pick != 1, pick != 0, draw_size(5, 12, 24), draw_size(6, 16, 40));
      nframes = $urandom_range(1, 3);
      for (f = 0; f < nframes; f++) begin
        total = rows_now * cols_now + cols_now;
        cut   = -1;
        if (total > 240)
          cut = $urandom_range(60, 240);
        else if (f == nframes - 1 && total > 1 && $urandom_range(0, 5) == 0)
          cut = $urandom_range(1, total - 1);
        run_frame(cut);
      end
    end

    // Drain everything still in flight, then give the verdict.
    settle();
    if (mismatches == 0 && backlog == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
design/bb3_pkg.sv
design/bb3_in_if.sv
design/bb3_out_if.sv
design/bb3_front.sv
design/bb3_cmd_queue.sv
design/bb3_back.sv
design/box_blur_3x3_clipped.sv
test/blur_monitor.sv
test/tb.sv
